/* src/gait_angle_stim_trigger_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the gait angle stimulation trigger
// Implication checks, same-cycle and next-cycle, reset aware.
// ----------------------------------------------------------------------------
`ifndef GAIT_ANGLE_STIM_TRIGGER_ASSERT_SVH
`define GAIT_ANGLE_STIM_TRIGGER_ASSERT_SVH

// Antecedent implies consequent in the same cycle
`define GAST_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gait_angle_stim_trigger: implication check failed");

// Antecedent implies consequent in the next cycle
`define GAST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gait_angle_stim_trigger: next-cycle check failed");

`endif

/* src/gast_pkg.sv */
// ----------------------------------------------------------------------------
// gast_pkg
// Shared types and constants of the gait angle stimulation trigger.
// ----------------------------------------------------------------------------
`default_nettype none

package gast_pkg;

    // Angle word, Q16.16
    localparam int ANGLE_W = 32;

    // Configuration register indexes
    localparam logic [1:0] REG_RATE_GAIN       = 2'd0;
    localparam logic [1:0] REG_STIM_ANGLE      = 2'd1;
    localparam logic [1:0] REG_WORK_AMPLITUDE  = 2'd2;
    localparam logic [1:0] REG_MAX_PERIOD_TIME = 2'd3;

    // Running max/min token handed from cell to cell
    typedef struct packed {
        logic                      valid;
        logic signed [ANGLE_W-1:0] max_val;
        logic signed [ANGLE_W-1:0] min_val;
    } token_t;

    // Sequencer states
    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_ACC    = 7'b0000010,
        ST_SHIFT  = 7'b0000100,
        ST_LAUNCH = 7'b0001000,
        ST_SCAN   = 7'b0010000,
        ST_MID    = 7'b0100000,
        ST_DECIDE = 7'b1000000
    } state_t;

endpackage

`default_nettype wire

/* src/gast_cell.sv */
// ----------------------------------------------------------------------------
// gast_cell
// One window entry. Shifts the angle line on command and folds its entry
// into the max/min token passing through, one cell per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module gast_cell
(
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   shift_en,
    input  wire logic signed [gast_pkg::ANGLE_W-1:0]    entry_in,
    output logic signed [gast_pkg::ANGLE_W-1:0]         entry_out,
    input  wire gast_pkg::token_t                       tok_in,
    output gast_pkg::token_t                            tok_out
);

    logic signed [gast_pkg::ANGLE_W-1:0] entry_reg;
    logic                                valid_reg;
    logic signed [gast_pkg::ANGLE_W-1:0] max_reg;
    logic signed [gast_pkg::ANGLE_W-1:0] min_reg;
    logic signed [gast_pkg::ANGLE_W-1:0] max_next;
    logic signed [gast_pkg::ANGLE_W-1:0] min_next;

    // Hold the window entry, advance it on a shift
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
        end
        else if (shift_en)
        begin
            entry_reg <= entry_in;
        end
    end

    // Fold this entry into the passing token
    always_comb
    begin
        max_next = ($signed(entry_reg) > $signed(tok_in.max_val)) ? entry_reg : tok_in.max_val;
        min_next = ($signed(entry_reg) < $signed(tok_in.min_val)) ? entry_reg : tok_in.min_val;
    end

    // Token valid travels with reset, payload without
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= tok_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tok_in.valid)
        begin
            max_reg <= max_next;
            min_reg <= min_next;
        end
    end

    assign entry_out       = entry_reg;
    assign tok_out.valid   = valid_reg;
    assign tok_out.max_val = max_reg;
    assign tok_out.min_val = min_reg;

endmodule

`default_nettype wire

/* src/gait_angle_stim_trigger.sv */
// ----------------------------------------------------------------------------
// gait_angle_stim_trigger
// Gyro-driven gait phase tracker that fires a one-sample stimulation pulse.
// ----------------------------------------------------------------------------
// Each gyro z sample passes through the accumulate, shift, launch, scan,
// midpoint and decision steps before the next sample is accepted. In the
// scan step a max/min token walks the row of WINDOW window cells one cell per
// cycle, so the swing search grows with the window size. A result waits in
// an output register, and the block only stalls at the decision step when
// that register is still full and m_axis_tready is low. The window resets
// to all zero.
`default_nettype none

module gait_angle_stim_trigger
#(
    parameter int WINDOW    = 128,
    parameter int TREND_LAG = 40
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Input stream; tdata: [7:0] gyro_z
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,
    // Result stream; tdata: [0] stim, [32:1] centred_angle,
    // [63:33] swing_amplitude, [64] rising, [71:65] zero
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [71:0]      m_axis_tdata,
    // Configuration write channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    localparam int AW      = gast_pkg::ANGLE_W;
    localparam int LAG     = (TREND_LAG > WINDOW) ? WINDOW : TREND_LAG;
    localparam int LAG_TAP = LAG - 2;

    // ------------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------------
    gast_pkg::state_t      state_reg, state_next;

    logic [15:0]           rate_gain_reg;
    logic signed [31:0]    stim_angle_reg;
    logic [30:0]           work_amplitude_reg;
    logic [15:0]           max_period_time_reg;

    logic signed [AW-1:0]  acc_reg;
    logic signed [AW-1:0]  prev_reg;
    logic signed [7:0]     gyro_reg;
    logic signed [AW-1:0]  dropped_reg;
    logic                  rising_reg;
    logic signed [AW-1:0]  max_reg;
    logic signed [AW-1:0]  min_reg;
    logic signed [AW:0]    diff_reg;
    logic signed [AW:0]    offset_reg;
    logic                  armed_reg, armed_next;
    logic [15:0]           count_reg, count_next;
    logic                  out_valid_reg;
    logic [71:0]           out_data_reg;

    // ------------------------------------------------------------------------
    // Cell row
    // ------------------------------------------------------------------------
    logic signed [AW-1:0]  entry [WINDOW];
    gast_pkg::token_t      tok [WINDOW+1];
    logic                  shift_en;

    assign shift_en            = (state_reg == gast_pkg::ST_SHIFT);
    assign tok[0].valid        = (state_reg == gast_pkg::ST_LAUNCH);
    assign tok[0].max_val      = dropped_reg;
    assign tok[0].min_val      = dropped_reg;

    for (genvar i = 0; i < WINDOW; i++)
    begin : g_cell
        logic signed [AW-1:0] entry_src;
        if (i == 0)
        begin : g_head
            assign entry_src = acc_reg;
        end
        else
        begin : g_body
            assign entry_src = entry[i-1];
        end
        gast_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .shift_en  (shift_en),
            .entry_in  (entry_src),
            .entry_out (entry[i]),
            .tok_in    (tok[i]),
            .tok_out   (tok[i+1])
        );
    end

    // ------------------------------------------------------------------------
    // Accumulate: gyro times gain, saturating add
    // ------------------------------------------------------------------------
    logic signed [24:0]    prod;
    logic signed [33:0]    sum;
    logic signed [AW-1:0]  sum_sat;

    always_comb
    begin
        prod = $signed(gyro_reg) * $signed({1'b0, rate_gain_reg});
        sum  = {{2{acc_reg[AW-1]}}, acc_reg} + {{9{prod[24]}}, prod};
        if (sum[33:31] == 3'b000 || sum[33:31] == 3'b111)
        begin
            sum_sat = sum[31:0];
        end
        else if (sum[33])
        begin
            sum_sat = {1'b1, {(AW-1){1'b0}}};
        end
        else
        begin
            sum_sat = {1'b0, {(AW-1){1'b1}}};
        end
    end

    // ------------------------------------------------------------------------
    // Midpoint and decision
    // ------------------------------------------------------------------------
    logic signed [AW:0]    diff_c;
    logic signed [AW:0]    offset_c;
    logic signed [AW+1:0]  centred;
    logic signed [AW+1:0]  prev_centred;
    logic signed [AW+1:0]  thresh;
    logic                  crossing;
    logic                  stim_c;
    logic signed [AW-1:0]  centred_sat;
    logic [30:0]           swing_sat;
    logic                  armed_mid;
    logic [15:0]           count_mid;
    logic                  decide_go;

    always_comb
    begin
        diff_c   = {max_reg[AW-1], max_reg} - {min_reg[AW-1], min_reg};
        offset_c = {max_reg[AW-1], max_reg} - (diff_c >>> 1);
    end

    always_comb
    begin
        centred      = {{2{acc_reg[AW-1]}}, acc_reg} - {offset_reg[AW], offset_reg};
        prev_centred = {{2{prev_reg[AW-1]}}, prev_reg} - {offset_reg[AW], offset_reg};
        thresh       = {{2{stim_angle_reg[31]}}, stim_angle_reg};
        crossing     = (prev_centred < thresh) && (centred > thresh) && rising_reg
                       && (diff_reg > $signed({2'b00, work_amplitude_reg}));

        // Arm or fire on a crossing
        stim_c    = 1'b0;
        armed_mid = armed_reg;
        count_mid = count_reg;
        if (crossing)
        begin
            count_mid = '0;
            if (armed_reg)
            begin
                stim_c = 1'b1;
            end
            else
            begin
                armed_mid = 1'b1;
            end
        end

        // Advance or expire the period timer
        armed_next = armed_mid;
        count_next = count_mid;
        if (armed_mid)
        begin
            if (count_mid < max_period_time_reg)
            begin
                count_next = count_mid + 16'd1;
            end
            else
            begin
                armed_next = 1'b0;
                count_next = '0;
            end
        end

        // Saturate output fields
        if (centred[AW+1:AW-1] == 3'b000 || centred[AW+1:AW-1] == 3'b111)
        begin
            centred_sat = centred[AW-1:0];
        end
        else if (centred[AW+1])
        begin
            centred_sat = {1'b1, {(AW-1){1'b0}}};
        end
        else
        begin
            centred_sat = {1'b0, {(AW-1){1'b1}}};
        end
        swing_sat = (diff_reg[AW:AW-1] != 2'b00) ? {31{1'b1}} : diff_reg[30:0];
    end

    assign decide_go = (state_reg == gast_pkg::ST_DECIDE) && (!out_valid_reg || m_axis_tready);

    // ------------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gast_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = gast_pkg::ST_ACC;
                end
            end
            gast_pkg::ST_ACC:    state_next = gast_pkg::ST_SHIFT;
            gast_pkg::ST_SHIFT:  state_next = gast_pkg::ST_LAUNCH;
            gast_pkg::ST_LAUNCH: state_next = gast_pkg::ST_SCAN;
            gast_pkg::ST_SCAN:
            begin
                if (tok[WINDOW].valid)
                begin
                    state_next = gast_pkg::ST_MID;
                end
            end
            gast_pkg::ST_MID:    state_next = gast_pkg::ST_DECIDE;
            gast_pkg::ST_DECIDE:
            begin
                if (decide_go)
                begin
                    state_next = gast_pkg::ST_IDLE;
                end
            end
            default:             state_next = gast_pkg::ST_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gast_pkg::ST_IDLE;
            acc_reg       <= '0;
            armed_reg     <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == gast_pkg::ST_ACC)
            begin
                acc_reg <= sum_sat;
            end
            if (decide_go)
            begin
                armed_reg     <= armed_next;
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            gyro_reg <= $signed(s_axis_tdata);
        end
        if (state_reg == gast_pkg::ST_ACC)
        begin
            prev_reg <= acc_reg;
        end
        if (shift_en)
        begin
            dropped_reg <= entry[WINDOW-1];
            rising_reg  <= acc_reg > entry[LAG_TAP];
        end
        if (state_reg == gast_pkg::ST_SCAN && tok[WINDOW].valid)
        begin
            max_reg <= tok[WINDOW].max_val;
            min_reg <= tok[WINDOW].min_val;
        end
        if (state_reg == gast_pkg::ST_MID)
        begin
            diff_reg   <= diff_c;
            offset_reg <= offset_c;
        end
        if (decide_go)
        begin
            out_data_reg <= {7'd0, rising_reg, swing_sat, centred_sat, stim_c};
        end
    end

    // ------------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_gain_reg       <= 16'd1000;
            stim_angle_reg      <= '0;
            work_amplitude_reg  <= 31'd655360;
            max_period_time_reg <= 16'd100;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                gast_pkg::REG_RATE_GAIN:       rate_gain_reg       <= cfg_data[15:0];
                gast_pkg::REG_STIM_ANGLE:      stim_angle_reg      <= $signed(cfg_data);
                gast_pkg::REG_WORK_AMPLITUDE:  work_amplitude_reg  <= cfg_data[30:0];
                gast_pkg::REG_MAX_PERIOD_TIME: max_period_time_reg <= cfg_data[15:0];
                default:                       rate_gain_reg       <= rate_gain_reg;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Ports
    // ------------------------------------------------------------------------
    assign s_axis_tready = (state_reg == gast_pkg::ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
`include "gait_angle_stim_trigger_assert.svh"

    // No token may still be walking the row when a new sample can enter
    `GAST_ASSERT_IMPL(a_idle_row_empty, clk, rst_n, s_axis_tready, !tok[WINDOW].valid)
    // The tail token only shows up while the sequencer waits for it
    `GAST_ASSERT_IMPL(a_tail_in_scan, clk, rst_n, tok[WINDOW].valid, state_reg == gast_pkg::ST_SCAN)
    // A fired pulse leaves the timer armed unless the period limit is zero
    `GAST_ASSERT_NEXT(a_stim_armed, clk, rst_n, decide_go && stim_c && (max_period_time_reg != 16'd0), armed_reg)

endmodule

`default_nettype wire
